[sv/ceq_pkg.sv]
package ceq_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0] CAP_RESET  = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] REAR_RESET = PTR_W'(DEPTH - 1);

    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_BACK   = 3'd3;
    localparam logic [2:0] MODE_CLEAR      = 3'd4;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rd_front;
        logic rd_back;
    } t_cmd;

endpackage

[sv/ceq_ctrl.sv]
module ceq_ctrl
    import ceq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output logic o_done,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RD_F  = 2'd1;
    localparam logic [1:0] ST_RD_B  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_RD_F;
                end
            end
            ST_RD_F: n_state = ST_RD_B;
            ST_RD_B: n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_done          = (r_state == ST_DONE);
    assign o_cmd.accept    = start && (r_state == ST_IDLE);
    assign o_cmd.rd_front  = (r_state == ST_RD_F);
    assign o_cmd.rd_back   = (r_state == ST_RD_B);

    // An accepted transaction always completes after the front and back reads.
    a_accept_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> ##2 o_done)
        else $error("result strobe did not follow an accepted transaction");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("controller stayed busy after the result strobe");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.accept, o_cmd.rd_front, o_cmd.rd_back, o_done}))
        else $error("controller issued overlapping commands");

endmodule

[sv/ceq_dp.sv]
module ceq_dp
    import ceq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic                     i_cfg_we,
    input  logic [CNT_W-1:0]         i_cfg_wdata,
    input  logic [2:0]               i_mode,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic signed [DATA_W-1:0] o_popped_value,
    output logic [1:0]               o_status,
    output logic [CNT_W-1:0]         o_count,
    output logic                     o_is_empty,
    output logic                     o_is_full,
    output logic signed [DATA_W-1:0] o_front_value,
    output logic signed [DATA_W-1:0] o_back_value
);

    logic [DATA_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]  r_cap;
    logic [PTR_W-1:0]  r_front, n_front;
    logic [PTR_W-1:0]  r_rear, n_rear;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [1:0]        r_status, n_status;
    logic              r_pop_ok, n_pop_ok;
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_popped;
    logic [DATA_W-1:0] r_front_val;

    logic [CNT_W-1:0]  eff_cap;
    logic              full;
    logic [PTR_W-1:0]  front_dn, front_up, rear_dn, rear_up;
    logic              we;
    logic [PTR_W-1:0]  wr_addr;
    logic [PTR_W-1:0]  rd_addr;

    always_comb begin
        // Out-of-range capacities are clamped: zero to one entry, above the store size to the store size.
        priority if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (r_cap > CNT_W'(DEPTH)) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = r_cap;
        end
    end

    assign full     = (r_count >= eff_cap);
    assign front_dn = (r_front == '0) ? PTR_W'(eff_cap - CNT_W'(1)) : r_front - PTR_W'(1);
    assign rear_dn  = (r_rear == '0) ? PTR_W'(eff_cap - CNT_W'(1)) : r_rear - PTR_W'(1);
    assign front_up = ((CNT_W'(r_front) + CNT_W'(1)) >= eff_cap) ? '0 : r_front + PTR_W'(1);
    assign rear_up  = ((CNT_W'(r_rear) + CNT_W'(1)) >= eff_cap) ? '0 : r_rear + PTR_W'(1);

    always_comb begin
        n_front  = r_front;
        n_rear   = r_rear;
        n_count  = r_count;
        n_status = r_status;
        n_pop_ok = r_pop_ok;
        we       = 1'b0;
        wr_addr  = r_front;
        if (i_cmd.accept) begin
            n_status = STATUS_DONE;
            n_pop_ok = 1'b0;
            unique case (i_mode)
                MODE_PUSH_FRONT: begin
                    if (full) begin
                        n_status = STATUS_FULL;
                    end else begin
                        n_front = front_dn;
                        wr_addr = front_dn;
                        we      = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                MODE_PUSH_BACK: begin
                    if (full) begin
                        n_status = STATUS_FULL;
                    end else begin
                        n_rear  = rear_up;
                        wr_addr = rear_up;
                        we      = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                MODE_POP_FRONT: begin
                    if (r_count == '0) begin
                        n_status = STATUS_EMPTY;
                    end else begin
                        n_front  = front_up;
                        n_pop_ok = 1'b1;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
                MODE_POP_BACK: begin
                    if (r_count == '0) begin
                        n_status = STATUS_EMPTY;
                    end else begin
                        n_rear   = rear_dn;
                        n_pop_ok = 1'b1;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
                MODE_CLEAR: begin
                    n_front = '0;
                    n_rear  = PTR_W'(eff_cap - CNT_W'(1));
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // On acceptance the read fetches the entry being popped; afterwards it
    // fetches the new front and then the new back.
    always_comb begin
        priority if (i_cmd.accept) begin
            rd_addr = (i_mode == MODE_POP_BACK) ? r_rear : r_front;
        end else if (i_cmd.rd_back) begin
            rd_addr = r_rear;
        end else begin
            rd_addr = r_front;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= i_push_value;
        end
        r_rd_data <= mem[rd_addr];
        if (i_cmd.rd_front) begin
            r_popped <= r_rd_data;
        end
        if (i_cmd.rd_back) begin
            r_front_val <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_RESET;
            r_front  <= '0;
            r_rear   <= REAR_RESET;
            r_count  <= '0;
            r_status <= STATUS_DONE;
            r_pop_ok <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_front  <= n_front;
            r_rear   <= n_rear;
            r_count  <= n_count;
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    assign o_is_empty     = (r_count == '0);
    assign o_is_full      = full;
    assign o_count        = r_count;
    assign o_status       = r_status;
    assign o_popped_value = r_pop_ok ? r_popped : '1;
    assign o_front_value  = o_is_empty ? '1 : r_front_val;
    assign o_back_value   = o_is_empty ? '1 : r_rd_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds the store size");

endmodule

[sv/circular_double_ended_queue_core.sv]
// Double-ended queue held in a circular 64-entry store.
// A transaction is accepted on a rising edge with start high and busy low;
// i_mode selects push front, push back, pop front, pop back or clear, and
// i_push_value carries the value for a push.
// The result appears after the front-read and back-read states and is valid
// for exactly one cycle while o_done is high. It carries the popped value
// (-1 if none), a status code, the count, the empty and full flags, and the
// values at the front and back (-1 when empty). The receiver cannot stall
// the block. A new transaction is accepted only once the last one is done:
// the single read port of the store is used in turn for the popped entry,
// the new front and the new back.
// i_cfg_we writes the capacity in use from i_cfg_wdata; write it only while
// busy is low, and follow a change with a clear.
// Synchronous reset empties the queue, sets the capacity to 64 and the rear
// pointer to 63. Store contents are not cleared; the user must see that they
// are read only after being written, which the block does not enforce.
module circular_double_ended_queue_core
    import ceq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CNT_W-1:0]         i_cfg_wdata,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               i_mode,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_popped_value,
    output logic [1:0]               o_status,
    output logic [CNT_W-1:0]         o_count,
    output logic                     o_is_empty,
    output logic                     o_is_full,
    output logic signed [DATA_W-1:0] o_front_value,
    output logic signed [DATA_W-1:0] o_back_value
);

    t_cmd cmd;

    ceq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    ceq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_mode         (i_mode),
        .i_push_value   (i_push_value),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_count        (o_count),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value)
    );

endmodule

[bench/deque_checker.sv]
module deque_checker
    import ceq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CNT_W-1:0]         i_cfg_wdata,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic [2:0]               i_mode,
    input  logic [DATA_W-1:0]        i_push_value,
    input  logic                     i_done,
    input  logic [DATA_W-1:0]        i_popped_value,
    input  logic [1:0]               i_status,
    input  logic [CNT_W-1:0]         i_count,
    input  logic                     i_is_empty,
    input  logic                     i_is_full,
    input  logic [DATA_W-1:0]        i_front_value,
    input  logic [DATA_W-1:0]        i_back_value,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] popped;
        logic [1:0]        status;
        logic [CNT_W-1:0]  count;
        logic              empty;
        logic              full;
        logic [DATA_W-1:0] front;
        logic [DATA_W-1:0] back;
    } t_deque_result;

    logic [DATA_W-1:0] slots [DEPTH];
    logic [PTR_W-1:0]  front_ptr;
    logic [PTR_W-1:0]  rear_ptr;
    logic [CNT_W-1:0]  entries;
    logic [CNT_W-1:0]  capacity;
    t_deque_result     awaited_results [$];
    int                failures = 0;
    int                waiting  = 0;

    assign o_fail_count = failures;
    assign o_pending    = waiting;

    function automatic logic [PTR_W-1:0] ptr_up(input logic [PTR_W-1:0] p, input int cap);
        return (int'(p) + 1 >= cap) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_down(input logic [PTR_W-1:0] p, input int cap);
        return (p == '0) ? PTR_W'(cap - 1) : p - PTR_W'(1);
    endfunction

    // Applies one queue operation to the shadow state and returns what the
    // block should report for it.
    function automatic t_deque_result deque_step(input logic [2:0] op,
                                                 input logic [DATA_W-1:0] value);
        t_deque_result r;
        int            cap;
        // Out-of-range capacities are clamped to the usable range.
        if (capacity == '0)
            cap = 1;
        else if (int'(capacity) > DEPTH)
            cap = DEPTH;
        else
            cap = int'(capacity);
        r.popped = '1;
        r.status = STATUS_DONE;
        case (op)
            MODE_PUSH_FRONT: begin
                if (int'(entries) >= cap) begin
                    r.status = STATUS_FULL;
                end else begin
                    front_ptr        = ptr_down(front_ptr, cap);
                    slots[front_ptr] = value;
                    entries          = entries + CNT_W'(1);
                end
            end
            MODE_PUSH_BACK: begin
                if (int'(entries) >= cap) begin
                    r.status = STATUS_FULL;
                end else begin
                    rear_ptr        = ptr_up(rear_ptr, cap);
                    slots[rear_ptr] = value;
                    entries         = entries + CNT_W'(1);
                end
            end
            MODE_POP_FRONT: begin
                if (entries == '0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    r.popped  = slots[front_ptr];
                    front_ptr = ptr_up(front_ptr, cap);
                    entries   = entries - CNT_W'(1);
                end
            end
            MODE_POP_BACK: begin
                if (entries == '0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    r.popped = slots[rear_ptr];
                    rear_ptr = ptr_down(rear_ptr, cap);
                    entries  = entries - CNT_W'(1);
                end
            end
            MODE_CLEAR: begin
                front_ptr = '0;
                rear_ptr  = PTR_W'(cap - 1);
                entries   = '0;
            end
            default: begin
            end
        endcase
        r.count = entries;
        r.empty = (entries == '0);
        r.full  = (int'(entries) >= cap);
        r.front = r.empty ? '1 : slots[front_ptr];
        r.back  = r.empty ? '1 : slots[rear_ptr];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_deque_result want;
        if (!i_rst_n) begin
            front_ptr = '0;
            rear_ptr  = REAR_RESET;
            entries   = '0;
            capacity  = CAP_RESET;
            awaited_results.delete();
        end else begin
            if (i_done) begin
                if (awaited_results.size() == 0) begin
                    failures++;
                    $display("%0t: result with no transaction outstanding", $time);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("popped_value", want.popped, i_popped_value);
                    check_field("status", DATA_W'(want.status), DATA_W'(i_status));
                    check_field("count", DATA_W'(want.count), DATA_W'(i_count));
                    check_field("is_empty", DATA_W'(want.empty), DATA_W'(i_is_empty));
                    check_field("is_full", DATA_W'(want.full), DATA_W'(i_is_full));
                    check_field("front_value", want.front, i_front_value);
                    check_field("back_value", want.back, i_back_value);
                end
            end
            if (i_cfg_we)
                capacity = i_cfg_wdata;
            if (i_start && !i_busy)
                awaited_results.push_back(deque_step(i_mode, i_push_value));
        end
        waiting = awaited_results.size();
    end

endmodule

[bench/tb.sv]
module tb;
    import ceq_pkg::*;

    localparam logic [2:0] MODE_UNUSED_LO  = 3'd5;
    localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
    localparam logic [2:0] MODE_UNUSED_HI  = 3'd7;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_cfg_we     = 1'b0;
    logic [CNT_W-1:0]         i_cfg_wdata  = '0;
    logic                     start        = 1'b0;
    logic                     busy;
    logic [2:0]               i_mode       = MODE_CLEAR;
    logic signed [DATA_W-1:0] i_push_value = '0;
    logic                     o_done;
    logic signed [DATA_W-1:0] o_popped_value;
    logic [1:0]               o_status;
    logic [CNT_W-1:0]         o_count;
    logic                     o_is_empty;
    logic                     o_is_full;
    logic signed [DATA_W-1:0] o_front_value;
    logic signed [DATA_W-1:0] o_back_value;
    int                       fail_count;
    int                       pending;
    int                       idle_pct = 0;

    always #1 i_clk = ~i_clk;

    circular_double_ended_queue_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_push_value   (i_push_value),
        .o_done         (o_done),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_count        (o_count),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value)
    );

    deque_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_start        (start),
        .i_busy         (busy),
        .i_mode         (i_mode),
        .i_push_value   (i_push_value),
        .i_done         (o_done),
        .i_popped_value (o_popped_value),
        .i_status       (o_status),
        .i_count        (o_count),
        .i_is_empty     (o_is_empty),
        .i_is_full      (o_is_full),
        .i_front_value  (o_front_value),
        .i_back_value   (o_back_value),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(15))
            0:       return {1'b0, {(DATA_W-1){1'b1}}};
            1:       return {1'b1, {(DATA_W-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Holds start until the transaction is taken, then maybe leaves a gap.
    task automatic send_op(input logic [2:0] op, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        start        <= 1'b1;
        i_mode       <= op;
        i_push_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(5)) @(negedge i_clk);
        end
    endtask

    // The capacity is only changed with the block idle and nothing in flight.
    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0 || busy) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int               idle_by_phase [3];
        int               push_pct;
        int               pick;
        logic [2:0]       op;
        logic [CNT_W-1:0] cap;

        idle_by_phase = '{0, 66, 30};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Refused pops on the empty queue, pushes of the extreme values from
        // both ends, the unused modes, then draining past empty.
        send_op(MODE_POP_FRONT, rand_value());
        send_op(MODE_POP_BACK, rand_value());
        send_op(MODE_PUSH_FRONT, 32'h7fff_ffff);
        send_op(MODE_PUSH_BACK, 32'h8000_0000);
        send_op(MODE_PUSH_FRONT, 32'hffff_ffff);
        send_op(MODE_PUSH_BACK, 32'h0000_0000);
        send_op(MODE_PUSH_FRONT, 32'h0000_0001);
        send_op(MODE_UNUSED_LO, rand_value());
        send_op(MODE_UNUSED_MID, rand_value());
        send_op(MODE_UNUSED_HI, rand_value());
        send_op(MODE_POP_FRONT, rand_value());
        send_op(MODE_POP_BACK, rand_value());
        send_op(MODE_POP_BACK, rand_value());
        send_op(MODE_POP_FRONT, rand_value());
        send_op(MODE_POP_FRONT, rand_value());
        send_op(MODE_POP_BACK, rand_value());
        send_op(MODE_CLEAR, rand_value());

        // Single-slot queue: pushes into a full queue are refused.
        write_capacity(7'd1);
        send_op(MODE_CLEAR, rand_value());
        send_op(MODE_PUSH_BACK, rand_value());
        send_op(MODE_PUSH_BACK, rand_value());
        send_op(MODE_PUSH_FRONT, rand_value());
        send_op(MODE_POP_FRONT, rand_value());

        // A capacity of zero behaves as one slot.
        write_capacity(7'd0);
        send_op(MODE_CLEAR, rand_value());
        send_op(MODE_PUSH_FRONT, rand_value());
        send_op(MODE_PUSH_BACK, rand_value());
        send_op(MODE_POP_BACK, rand_value());

        // Write every slot of the store once, so that later capacity changes
        // without a clear never expose a slot that was never written.
        write_capacity(CAP_RESET);
        send_op(MODE_CLEAR, rand_value());
        repeat (DEPTH) send_op(MODE_PUSH_BACK, rand_value());
        send_op(MODE_PUSH_FRONT, rand_value());

        for (int phase = 0; phase < 3; phase++) begin
            for (int seg = 0; seg < 6; seg++) begin
                idle_pct = ($urandom_range(3) == 0) ? 0 : idle_by_phase[phase];
                case ($urandom_range(5))
                    0:       cap = 7'd1;
                    1:       cap = 7'd2;
                    2:       cap = CNT_W'($urandom_range(3, DEPTH - 1));
                    3:       cap = CAP_RESET;
                    4:       cap = 7'd0;
                    default: cap = CNT_W'($urandom_range(DEPTH + 1, 127));
                endcase
                write_capacity(cap);
                // Now and then the capacity changes with the contents kept.
                if ($urandom_range(3) != 0)
                    send_op(MODE_CLEAR, rand_value());
                case ($urandom_range(2))
                    0:       push_pct = 25;
                    1:       push_pct = 50;
                    default: push_pct = 80;
                endcase
                repeat ($urandom_range(25, 40)) begin
                    pick = $urandom_range(99);
                    if (pick < 3)
                        op = MODE_CLEAR;
                    else if (pick < 6)
                        op = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
                    else if ($urandom_range(99) < push_pct)
                        op = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
                    else
                        op = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
                    send_op(op, rand_value());
                end
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
